FILE: src/mg3d_pkg.sv
package mg3d_pkg;

    localparam int MAX_DIM_X   = 64;
    localparam int MAX_DIM_Y   = 64;
    localparam int MAX_DIM_Z   = 64;
    localparam int MAX_KERNEL  = 8;
    localparam int SAMPLE_BITS = 16;

    localparam int COORD_W      = 6;
    localparam int VOL_SIZE_W   = 7;
    localparam int KER_SIZE_W   = 4;
    localparam int VALUE_W      = 16;
    localparam int VOL_SIZE_RST = 64;
    localparam int KER_SIZE_RST = 1;

    localparam logic [1:0] ACT_MASK    = 2'd0;
    localparam logic [1:0] ACT_VOXEL   = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;
    localparam logic [1:0] ACT_NOP     = 2'd3;

    localparam logic [2:0] REG_VOL_X = 3'd0;
    localparam logic [2:0] REG_VOL_Y = 3'd1;
    localparam logic [2:0] REG_VOL_Z = 3'd2;
    localparam logic [2:0] REG_KER_X = 3'd3;
    localparam logic [2:0] REG_KER_Y = 3'd4;
    localparam logic [2:0] REG_KER_Z = 3'd5;
    localparam int         REG_COUNT = 6;

    localparam int DIM_XY  = (MAX_DIM_X > MAX_DIM_Y) ? MAX_DIM_X : MAX_DIM_Y;
    localparam int DIM_TOP = (DIM_XY > MAX_DIM_Z) ? DIM_XY : MAX_DIM_Z;
    localparam int VD_W    = $clog2(DIM_TOP + 1);
    localparam int KS_W    = $clog2(MAX_KERNEL + 1);
    localparam int KI_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int NW_A    = COORD_W + KI_W + 2;
    localparam int NW_B    = VD_W + 1;
    localparam int NW      = (NW_A > NW_B) ? NW_A : NW_B;

    localparam int VOL_DEPTH  = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
    localparam int VA_W       = (VOL_DEPTH > 1) ? $clog2(VOL_DEPTH) : 1;
    localparam int MASK_DEPTH = MAX_KERNEL * MAX_KERNEL * MAX_KERNEL;
    localparam int MA_W       = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
    } t_scan_ctrl;

    typedef struct packed {
        logic            busy;
        logic            inrange;
        logic [VA_W-1:0] vaddr;
        logic [MA_W-1:0] maddr;
    } t_scan_stat;

    function automatic logic [VA_W-1:0] vol_index(input logic [NW-1:0] x,
                                                  input logic [NW-1:0] y,
                                                  input logic [NW-1:0] z);
        return VA_W'(z) * VA_W'(MAX_DIM_X * MAX_DIM_Y) + VA_W'(y) * VA_W'(MAX_DIM_X)
             + VA_W'(x);
    endfunction

    function automatic logic [MA_W-1:0] mask_index(input logic [KI_W-1:0] x,
                                                   input logic [KI_W-1:0] y,
                                                   input logic [KI_W-1:0] z);
        return MA_W'(z) * MA_W'(MAX_KERNEL * MAX_KERNEL) + MA_W'(y) * MA_W'(MAX_KERNEL)
             + MA_W'(x);
    endfunction

endpackage

FILE: src/mg3d_ram.sv
module mg3d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/mg3d_scan.sv
module mg3d_scan (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mg3d_pkg::t_scan_ctrl                   i_ctrl,
    input  logic [2:0][mg3d_pkg::KS_W-1:0]         i_kd,
    input  logic [2:0][mg3d_pkg::VD_W-1:0]         i_vd,
    output mg3d_pkg::t_scan_stat                   o_stat
);

    logic                      r_busy;
    logic [mg3d_pkg::KI_W-1:0] r_dx;
    logic [mg3d_pkg::KI_W-1:0] r_dy;
    logic [mg3d_pkg::KI_W-1:0] r_dz;
    logic                      w_lx;
    logic                      w_ly;
    logic                      w_lz;
    logic [mg3d_pkg::NW-1:0]   w_nx;
    logic [mg3d_pkg::NW-1:0]   w_ny;
    logic [mg3d_pkg::NW-1:0]   w_nz;
    logic                      w_inx;
    logic                      w_iny;
    logic                      w_inz;

    assign w_lx = (mg3d_pkg::KS_W'(r_dx) + mg3d_pkg::KS_W'(1)) == i_kd[0];
    assign w_ly = (mg3d_pkg::KS_W'(r_dy) + mg3d_pkg::KS_W'(1)) == i_kd[1];
    assign w_lz = (mg3d_pkg::KS_W'(r_dz) + mg3d_pkg::KS_W'(1)) == i_kd[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dx   <= '0;
            r_dy   <= '0;
            r_dz   <= '0;
        end else if (i_ctrl.start) begin
            r_busy <= (i_kd[0] != '0) && (i_kd[1] != '0) && (i_kd[2] != '0);
            r_dx   <= '0;
            r_dy   <= '0;
            r_dz   <= '0;
        end else if (r_busy) begin
            if (w_lx) begin
                r_dx <= '0;
                if (w_ly) begin
                    r_dy <= '0;
                    if (w_lz) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_dz <= r_dz + mg3d_pkg::KI_W'(1);
                    end
                end else begin
                    r_dy <= r_dy + mg3d_pkg::KI_W'(1);
                end
            end else begin
                r_dx <= r_dx + mg3d_pkg::KI_W'(1);
            end
        end
    end

    assign w_nx = mg3d_pkg::NW'(i_ctrl.cx) + mg3d_pkg::NW'(r_dx) - mg3d_pkg::NW'(i_kd[0] >> 1);
    assign w_ny = mg3d_pkg::NW'(i_ctrl.cy) + mg3d_pkg::NW'(r_dy) - mg3d_pkg::NW'(i_kd[1] >> 1);
    assign w_nz = mg3d_pkg::NW'(i_ctrl.cz) + mg3d_pkg::NW'(r_dz) - mg3d_pkg::NW'(i_kd[2] >> 1);

    assign w_inx = !w_nx[mg3d_pkg::NW-1] && (w_nx < mg3d_pkg::NW'(i_vd[0]));
    assign w_iny = !w_ny[mg3d_pkg::NW-1] && (w_ny < mg3d_pkg::NW'(i_vd[1]));
    assign w_inz = !w_nz[mg3d_pkg::NW-1] && (w_nz < mg3d_pkg::NW'(i_vd[2]));

    always_comb begin
        o_stat.busy    = r_busy;
        o_stat.inrange = w_inx && w_iny && w_inz;
        o_stat.vaddr   = mg3d_pkg::vol_index(w_nx, w_ny, w_nz);
        o_stat.maddr   = mg3d_pkg::mask_index(r_dx, r_dy, r_dz);
    end

endmodule

FILE: src/masked_3d_grayscale_dilation.sv
// Masked grayscale 3D dilation. A voxel load or mask load whose coordinate is rejected
// issues an error result, as does a rejected compute. During a compute the kernel walker
// visits one kernel position per cycle, with one read of the mask store and one read of
// the volume store per position, and the compare against the running maximum follows in
// the cycle after. After reset the block clears all 512 entries of the mask store
// (MAX_KERNEL cubed), one entry per cycle, before its input accepts a transaction;
// configuration writes are taken throughout. A finished result waits in the output
// register while the next transaction is accepted; a further result holds the block
// until that register drains.
module masked_3d_grayscale_dilation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // coord_x[5:0], coord_y[11:6], coord_z[17:12], sample_value[33:18], mask_bit[34]
    input  logic [39:0] i_s_tdata,
    // action[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // max_value[15:0]
    output logic [15:0] o_m_tdata,
    // coord_error[0]
    output logic [0:0]  o_m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    localparam int VDX_RST = (mg3d_pkg::MAX_DIM_X < mg3d_pkg::VOL_SIZE_RST) ?
                             mg3d_pkg::MAX_DIM_X : mg3d_pkg::VOL_SIZE_RST;
    localparam int VDY_RST = (mg3d_pkg::MAX_DIM_Y < mg3d_pkg::VOL_SIZE_RST) ?
                             mg3d_pkg::MAX_DIM_Y : mg3d_pkg::VOL_SIZE_RST;
    localparam int VDZ_RST = (mg3d_pkg::MAX_DIM_Z < mg3d_pkg::VOL_SIZE_RST) ?
                             mg3d_pkg::MAX_DIM_Z : mg3d_pkg::VOL_SIZE_RST;
    localparam int KD_RST  = (mg3d_pkg::MAX_KERNEL < mg3d_pkg::KER_SIZE_RST) ?
                             mg3d_pkg::MAX_KERNEL : mg3d_pkg::KER_SIZE_RST;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESULT
    } t_state;

    t_state                                     r_state;
    logic [mg3d_pkg::MA_W-1:0]                  r_clr;
    logic [2:0][mg3d_pkg::VD_W-1:0]             r_vd;
    logic [2:0][mg3d_pkg::KS_W-1:0]             r_kd;
    logic [1:0]                                 r_action;
    logic [mg3d_pkg::COORD_W-1:0]               r_cx;
    logic [mg3d_pkg::COORD_W-1:0]               r_cy;
    logic [mg3d_pkg::COORD_W-1:0]               r_cz;
    logic signed [mg3d_pkg::SAMPLE_BITS-1:0]    r_sample;
    logic                                       r_mask_bit;
    logic                                       r_first;
    logic                                       r_pv;
    logic signed [mg3d_pkg::SAMPLE_BITS-1:0]    r_best;
    logic                                       r_res_err;
    logic                                       r_out_valid;
    logic [mg3d_pkg::VALUE_W-1:0]               r_out_max;
    logic                                       r_out_err;

    logic signed [mg3d_pkg::VALUE_W-1:0]        w_in_sample;
    logic                                       w_err_k;
    logic                                       w_err_v;
    logic [mg3d_pkg::VA_W-1:0]                  w_center;
    logic [mg3d_pkg::MA_W-1:0]                  w_mask_load_addr;
    mg3d_pkg::t_scan_ctrl                       w_ctrl;
    mg3d_pkg::t_scan_stat                       w_scan;
    logic                                       w_vox_we;
    logic [mg3d_pkg::VA_W-1:0]                  w_vox_raddr;
    logic [mg3d_pkg::SAMPLE_BITS-1:0]           w_vox_rd;
    logic                                       w_mask_we;
    logic [mg3d_pkg::MA_W-1:0]                  w_mask_waddr;
    logic [0:0]                                 w_mask_wd;
    logic [0:0]                                 w_mask_rd;

    assign w_in_sample = i_s_tdata[33:18];

    assign w_err_k = (mg3d_pkg::NW'(r_cx) >= mg3d_pkg::NW'(r_kd[0]))
                  || (mg3d_pkg::NW'(r_cy) >= mg3d_pkg::NW'(r_kd[1]))
                  || (mg3d_pkg::NW'(r_cz) >= mg3d_pkg::NW'(r_kd[2]));
    assign w_err_v = (mg3d_pkg::NW'(r_cx) >= mg3d_pkg::NW'(r_vd[0]))
                  || (mg3d_pkg::NW'(r_cy) >= mg3d_pkg::NW'(r_vd[1]))
                  || (mg3d_pkg::NW'(r_cz) >= mg3d_pkg::NW'(r_vd[2]));

    assign w_center = mg3d_pkg::vol_index(mg3d_pkg::NW'(r_cx), mg3d_pkg::NW'(r_cy),
                                          mg3d_pkg::NW'(r_cz));
    assign w_mask_load_addr = mg3d_pkg::mask_index(mg3d_pkg::KI_W'(r_cx),
                                                   mg3d_pkg::KI_W'(r_cy),
                                                   mg3d_pkg::KI_W'(r_cz));

    always_comb begin
        w_ctrl.start = (r_state == ST_EXEC) && (r_action == mg3d_pkg::ACT_COMPUTE) && !w_err_v;
        w_ctrl.cx    = r_cx;
        w_ctrl.cy    = r_cy;
        w_ctrl.cz    = r_cz;
    end

    always_comb begin
        w_vox_we    = (r_state == ST_EXEC) && (r_action == mg3d_pkg::ACT_VOXEL) && !w_err_v;
        w_vox_raddr = (r_state == ST_EXEC) ? w_center : w_scan.vaddr;
        if (r_state == ST_CLEAR) begin
            w_mask_we    = 1'b1;
            w_mask_waddr = r_clr;
            w_mask_wd    = 1'b0;
        end else begin
            w_mask_we    = (r_state == ST_EXEC) && (r_action == mg3d_pkg::ACT_MASK) && !w_err_k;
            w_mask_waddr = w_mask_load_addr;
            w_mask_wd    = r_mask_bit;
        end
    end

    mg3d_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_kd    (r_kd),
        .i_vd    (r_vd),
        .o_stat  (w_scan)
    );

    mg3d_ram #(
        .WIDTH (mg3d_pkg::SAMPLE_BITS),
        .DEPTH (mg3d_pkg::VOL_DEPTH)
    ) u_voxel_store (
        .i_clk   (i_clk),
        .i_we    (w_vox_we),
        .i_waddr (w_center),
        .i_wdata (r_sample),
        .i_raddr (w_vox_raddr),
        .o_rdata (w_vox_rd)
    );

    mg3d_ram #(
        .WIDTH (1),
        .DEPTH (mg3d_pkg::MASK_DEPTH)
    ) u_mask_store (
        .i_clk   (i_clk),
        .i_we    (w_mask_we),
        .i_waddr (w_mask_waddr),
        .i_wdata (w_mask_wd),
        .i_raddr (w_scan.maddr),
        .o_rdata (w_mask_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_vd[0]     <= mg3d_pkg::VD_W'(VDX_RST);
            r_vd[1]     <= mg3d_pkg::VD_W'(VDY_RST);
            r_vd[2]     <= mg3d_pkg::VD_W'(VDZ_RST);
            r_kd[0]     <= mg3d_pkg::KS_W'(KD_RST);
            r_kd[1]     <= mg3d_pkg::KS_W'(KD_RST);
            r_kd[2]     <= mg3d_pkg::KS_W'(KD_RST);
            r_first     <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mg3d_pkg::REG_VOL_X: r_vd[0] <= (int'(i_cfg_data) > mg3d_pkg::MAX_DIM_X) ?
                                          mg3d_pkg::VD_W'(mg3d_pkg::MAX_DIM_X) :
                                          mg3d_pkg::VD_W'(i_cfg_data);
                    mg3d_pkg::REG_VOL_Y: r_vd[1] <= (int'(i_cfg_data) > mg3d_pkg::MAX_DIM_Y) ?
                                          mg3d_pkg::VD_W'(mg3d_pkg::MAX_DIM_Y) :
                                          mg3d_pkg::VD_W'(i_cfg_data);
                    mg3d_pkg::REG_VOL_Z: r_vd[2] <= (int'(i_cfg_data) > mg3d_pkg::MAX_DIM_Z) ?
                                          mg3d_pkg::VD_W'(mg3d_pkg::MAX_DIM_Z) :
                                          mg3d_pkg::VD_W'(i_cfg_data);
                    mg3d_pkg::REG_KER_X: r_kd[0] <=
                                          (int'(i_cfg_data[3:0]) > mg3d_pkg::MAX_KERNEL) ?
                                          mg3d_pkg::KS_W'(mg3d_pkg::MAX_KERNEL) :
                                          mg3d_pkg::KS_W'(i_cfg_data[3:0]);
                    mg3d_pkg::REG_KER_Y: r_kd[1] <=
                                          (int'(i_cfg_data[3:0]) > mg3d_pkg::MAX_KERNEL) ?
                                          mg3d_pkg::KS_W'(mg3d_pkg::MAX_KERNEL) :
                                          mg3d_pkg::KS_W'(i_cfg_data[3:0]);
                    mg3d_pkg::REG_KER_Z: r_kd[2] <=
                                          (int'(i_cfg_data[3:0]) > mg3d_pkg::MAX_KERNEL) ?
                                          mg3d_pkg::KS_W'(mg3d_pkg::MAX_KERNEL) :
                                          mg3d_pkg::KS_W'(i_cfg_data[3:0]);
                    default: ;
                endcase
            end

            if (r_out_valid && i_m_tready && (r_state != ST_RESULT)) begin
                r_out_valid <= 1'b0;
            end

            r_first <= w_ctrl.start;
            r_pv    <= w_scan.busy && w_scan.inrange;

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + mg3d_pkg::MA_W'(1);
                    if (r_clr == mg3d_pkg::MA_W'(mg3d_pkg::MASK_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_action   <= i_s_tuser;
                        r_cx       <= i_s_tdata[5:0];
                        r_cy       <= i_s_tdata[11:6];
                        r_cz       <= i_s_tdata[17:12];
                        r_sample   <= mg3d_pkg::SAMPLE_BITS'(w_in_sample);
                        r_mask_bit <= i_s_tdata[34];
                        r_state    <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    unique case (r_action)
                        mg3d_pkg::ACT_MASK: begin
                            r_res_err <= 1'b1;
                            r_state   <= w_err_k ? ST_RESULT : ST_IDLE;
                        end
                        mg3d_pkg::ACT_VOXEL: begin
                            r_res_err <= 1'b1;
                            r_state   <= w_err_v ? ST_RESULT : ST_IDLE;
                        end
                        mg3d_pkg::ACT_COMPUTE: begin
                            r_res_err <= w_err_v;
                            r_state   <= w_err_v ? ST_RESULT : ST_SCAN;
                        end
                        default: r_state <= ST_IDLE;
                    endcase
                end
                ST_SCAN: begin
                    if (r_first) begin
                        r_best <= signed'(w_vox_rd);
                    end else if (r_pv && w_mask_rd[0] && (signed'(w_vox_rd) > r_best)) begin
                        r_best <= signed'(w_vox_rd);
                    end
                    if (!w_scan.busy && !r_pv && !r_first) begin
                        r_state <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_max   <= r_res_err ? '0 : mg3d_pkg::VALUE_W'(r_best);
                        r_out_err   <= r_res_err;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_max;
    assign o_m_tuser   = r_out_err;
    assign o_cfg_ready = 1'b1;

    a_result_from_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == ST_RESULT))
        else $error("result raised outside the result state");

    a_error_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("error result carries a nonzero value");

    a_walker_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SCAN) |-> !w_scan.busy)
        else $error("kernel walker busy outside the scan state");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

typedef struct {
    logic [mg3d_pkg::VALUE_W-1:0] max_value;
    logic                         coord_error;
} t_dilation;

class dilation_scoreboard;
    logic signed [mg3d_pkg::VALUE_W-1:0] voxels [mg3d_pkg::VOL_DEPTH];
    bit                        written [mg3d_pkg::VOL_DEPTH];
    bit                        mask_bits [mg3d_pkg::MASK_DEPTH];
    logic [6:0]                regs [mg3d_pkg::REG_COUNT] = '{
        7'(mg3d_pkg::VOL_SIZE_RST), 7'(mg3d_pkg::VOL_SIZE_RST), 7'(mg3d_pkg::VOL_SIZE_RST),
        7'(mg3d_pkg::KER_SIZE_RST), 7'(mg3d_pkg::KER_SIZE_RST), 7'(mg3d_pkg::KER_SIZE_RST)};
    t_dilation                 expected_dilations [$];
    int                        missing [$];
    int                        errors = 0;

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function int pending();
        return expected_dilations.size();
    endfunction

    function int vol_dim(int a);
        int lim [3] = '{mg3d_pkg::MAX_DIM_X, mg3d_pkg::MAX_DIM_Y, mg3d_pkg::MAX_DIM_Z};
        return (int'(regs[a]) > lim[a]) ? lim[a] : int'(regs[a]);
    endfunction

    function int ker_dim(int a);
        return (int'(regs[mg3d_pkg::REG_KER_X + a]) > mg3d_pkg::MAX_KERNEL) ?
               mg3d_pkg::MAX_KERNEL : int'(regs[mg3d_pkg::REG_KER_X + a]);
    endfunction

    function int voxel_addr(int x, int y, int z);
        return (z * mg3d_pkg::MAX_DIM_Y + y) * mg3d_pkg::MAX_DIM_X + x;
    endfunction

    function void write_reg(int idx, logic [6:0] data);
        if (idx < mg3d_pkg::REG_COUNT)
            regs[idx] = (idx >= mg3d_pkg::REG_KER_X) ? {3'd0, data[3:0]} : data;
    endfunction

    // walk the masked kernel box; optionally list the voxels it would read unwritten
    function logic signed [mg3d_pkg::VALUE_W-1:0] walk_box(int cx, int cy, int cz,
                                                           bit collect);
        int vd [3];
        int kd [3];
        int nx, ny, nz, idx;
        logic signed [mg3d_pkg::VALUE_W-1:0] best;
        for (int a = 0; a < 3; a++) begin
            vd[a] = vol_dim(a);
            kd[a] = ker_dim(a);
        end
        idx = voxel_addr(cx, cy, cz);
        if (collect && !written[idx])
            missing.push_back(idx);
        best = voxels[idx];
        for (int dz = 0; dz < kd[2]; dz++) begin
            nz = cz + dz - kd[2] / 2;
            if (nz < 0 || nz >= vd[2])
                continue;
            for (int dy = 0; dy < kd[1]; dy++) begin
                ny = cy + dy - kd[1] / 2;
                if (ny < 0 || ny >= vd[1])
                    continue;
                for (int dx = 0; dx < kd[0]; dx++) begin
                    nx = cx + dx - kd[0] / 2;
                    if (nx < 0 || nx >= vd[0])
                        continue;
                    if (!mask_bits[(dz * mg3d_pkg::MAX_KERNEL + dy) * mg3d_pkg::MAX_KERNEL
                                   + dx])
                        continue;
                    idx = voxel_addr(nx, ny, nz);
                    if (collect && !written[idx])
                        missing.push_back(idx);
                    if (voxels[idx] > best)
                        best = voxels[idx];
                end
            end
        end
        return best;
    endfunction

    function void accept_item(logic [1:0] action, logic [5:0] x, logic [5:0] y,
                              logic [5:0] z, logic [mg3d_pkg::VALUE_W-1:0] value,
                              logic mbit);
        t_dilation rejected;
        t_dilation dilated;
        rejected.max_value   = '0;
        rejected.coord_error = 1'b1;
        case (action)
            mg3d_pkg::ACT_MASK: begin
                if (x >= ker_dim(0) || y >= ker_dim(1) || z >= ker_dim(2))
                    expected_dilations.push_back(rejected);
                else
                    mask_bits[(z * mg3d_pkg::MAX_KERNEL + y) * mg3d_pkg::MAX_KERNEL + x] = mbit;
            end
            mg3d_pkg::ACT_VOXEL, mg3d_pkg::ACT_COMPUTE: begin
                if (x >= vol_dim(0) || y >= vol_dim(1) || z >= vol_dim(2)) begin
                    expected_dilations.push_back(rejected);
                end else if (action == mg3d_pkg::ACT_VOXEL) begin
                    voxels[voxel_addr(x, y, z)]  = value;
                    written[voxel_addr(x, y, z)] = 1'b1;
                end else begin
                    dilated.max_value   = walk_box(x, y, z, 1'b0);
                    dilated.coord_error = 1'b0;
                    expected_dilations.push_back(dilated);
                end
            end
            default: ;
        endcase
    endfunction

    task check_result(logic [mg3d_pkg::VALUE_W-1:0] max_value, logic coord_error);
        t_dilation want;
        if (expected_dilations.size() == 0) begin
            report($sformatf("unexpected result max_value=%h coord_error=%b",
                             max_value, coord_error));
        end else begin
            want = expected_dilations.pop_front();
            if (max_value !== want.max_value)
                report($sformatf("max_value %h, want %h", max_value, want.max_value));
            if (coord_error !== want.coord_error)
                report($sformatf("coord_error %b, want %b", coord_error, want.coord_error));
        end
    endtask
endclass

module tb;
    localparam int STALL_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PHASES          = 12;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = mg3d_pkg::ACT_NOP;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [6:0]  cfg_data  = '0;

    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        o_cfg_ready;

    int tx_idle_pct = 17;
    int rx_idle_pct = 61;
    int idle_cycles = 0;

    int cfg_plan [PHASES][mg3d_pkg::REG_COUNT] = '{
        '{64, 64, 64, 1, 1, 1},
        '{4, 4, 4, 3, 3, 3},
        '{1, 1, 1, 8, 8, 8},
        '{64, 64, 64, 2, 2, 2},
        '{0, 5, 3, 3, 3, 3},
        '{127, 70, 2, 15, 9, 1},
        '{5, 3, 6, 0, 4, 0},
        '{6, 5, 4, 5, 6, 7},
        '{3, 64, 2, 4, 8, 2},
        '{7, 7, 7, 8, 8, 8},
        '{4, 4, 4, 2, 2, 2},
        '{4, 4, 4, 2, 2, 2}
    };

    dilation_scoreboard sb;

    masked_3d_grayscale_dilation dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && o_m_tvalid && m_tready)
            sb.check_result(o_m_tdata, o_m_tuser[0]);
    end

    always @(posedge clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) || (cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_cmd(logic [1:0] action, int x, int y, int z,
                            logic [15:0] value, logic mbit);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {5'd0, mbit, value, z[5:0], y[5:0], x[5:0]};
        do @(posedge clk); while (!o_s_tready);
        sb.accept_item(action, x[5:0], y[5:0], z[5:0], value, mbit);
    endtask

    task automatic write_reg(int idx, logic [6:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[2:0];
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // hold the input until every pending result is out, then let the block settle
    task automatic drain(int extra);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic configure(int ph);
        logic [6:0] data;
        for (int r = 0; r < mg3d_pkg::REG_COUNT; r++) begin
            data = 7'(cfg_plan[ph][r]);
            if (r >= mg3d_pkg::REG_KER_X)
                data[6:4] = 3'($urandom_range(0, 7));
            write_reg(r, data);
        end
        if (ph == 6) begin
            write_reg(mg3d_pkg::REG_COUNT, 7'($urandom_range(0, 127)));
            write_reg(mg3d_pkg::REG_COUNT + 1, 7'($urandom_range(0, 127)));
        end
    endtask

    function automatic int pick_coord(int dim);
        if (dim == 0)
            return $urandom_range(0, 63);
        if (dim <= mg3d_pkg::MAX_KERNEL)
            return $urandom_range(0, dim - 1);
        // cluster on the low and high faces so voxel reuse stays high
        if ($urandom_range(0, 1))
            return $urandom_range(0, 3);
        return $urandom_range(dim - 4, dim - 1);
    endfunction

    task automatic run_directed();
        send_cmd(mg3d_pkg::ACT_VOXEL, 63, 63, 63, 16'h7fff, 1'b0);
        send_cmd(mg3d_pkg::ACT_VOXEL, 0, 0, 0, 16'h8000, 1'b1);
        send_cmd(mg3d_pkg::ACT_COMPUTE, 63, 63, 63, 16'h0000, 1'b0);
        send_cmd(mg3d_pkg::ACT_COMPUTE, 0, 0, 0, 16'hffff, 1'b1);
        send_cmd(mg3d_pkg::ACT_MASK, 0, 0, 0, 16'h1234, 1'b1);
        send_cmd(mg3d_pkg::ACT_MASK, 1, 0, 0, 16'hffff, 1'b1);
        send_cmd(mg3d_pkg::ACT_MASK, 0, 63, 0, 16'h0000, 1'b0);
        send_cmd(mg3d_pkg::ACT_MASK, 0, 0, 5, 16'h5555, 1'b1);
        send_cmd(mg3d_pkg::ACT_MASK, 63, 63, 63, 16'haaaa, 1'b0);
        send_cmd(mg3d_pkg::ACT_NOP, 42, 21, 63, 16'hffff, 1'b1);
        send_cmd(mg3d_pkg::ACT_VOXEL, 1, 0, 0, 16'hffff, 1'b0);
        send_cmd(mg3d_pkg::ACT_COMPUTE, 0, 0, 0, 16'h0000, 1'b0);
        send_cmd(mg3d_pkg::ACT_VOXEL, 32, 16, 8, 16'h0000, 1'b1);
        send_cmd(mg3d_pkg::ACT_COMPUTE, 32, 16, 8, 16'h8000, 1'b1);
        send_cmd(mg3d_pkg::ACT_VOXEL, 42, 21, 63, 16'h5555, 1'b0);
        send_cmd(mg3d_pkg::ACT_VOXEL, 21, 42, 0, 16'haaaa, 1'b1);
        send_cmd(mg3d_pkg::ACT_COMPUTE, 42, 21, 63, 16'h0000, 1'b0);
        send_cmd(mg3d_pkg::ACT_COMPUTE, 21, 42, 0, 16'h7fff, 1'b0);
        send_cmd(mg3d_pkg::ACT_NOP, 0, 0, 0, 16'h0000, 1'b0);
        send_cmd(mg3d_pkg::ACT_COMPUTE, 63, 63, 63, 16'h1234, 1'b1);
    endtask

    task automatic run_random(int n);
        int  count;
        int  r, x, y, z, idx;
        bit  wide;
        count = 0;
        while (count < n) begin
            r    = $urandom_range(0, 99);
            wide = ($urandom_range(0, 9) == 0);
            if (r < 4) begin
                send_cmd(mg3d_pkg::ACT_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 63), 16'($urandom), 1'($urandom_range(0, 1)));
            end else if (r < 20) begin
                x = wide ? $urandom_range(0, 63) : pick_coord(sb.ker_dim(0));
                y = wide ? $urandom_range(0, 63) : pick_coord(sb.ker_dim(1));
                z = wide ? $urandom_range(0, 63) : pick_coord(sb.ker_dim(2));
                send_cmd(mg3d_pkg::ACT_MASK, x, y, z, 16'($urandom),
                         ($urandom_range(0, 9) < 6));
                count++;
            end else begin
                x = wide ? $urandom_range(0, 63) : pick_coord(sb.vol_dim(0));
                y = wide ? $urandom_range(0, 63) : pick_coord(sb.vol_dim(1));
                z = wide ? $urandom_range(0, 63) : pick_coord(sb.vol_dim(2));
                if (r < 48) begin
                    send_cmd(mg3d_pkg::ACT_VOXEL, x, y, z, 16'($urandom),
                             1'($urandom_range(0, 1)));
                    count++;
                end else begin
                    // fill every voxel the compute will read before asking for it
                    if (x < sb.vol_dim(0) && y < sb.vol_dim(1) && z < sb.vol_dim(2)) begin
                        sb.missing.delete();
                        void'(sb.walk_box(x, y, z, 1'b1));
                        foreach (sb.missing[i]) begin
                            idx = sb.missing[i];
                            if (!sb.written[idx]) begin
                                send_cmd(mg3d_pkg::ACT_VOXEL, idx % mg3d_pkg::MAX_DIM_X,
                                         (idx / mg3d_pkg::MAX_DIM_X) % mg3d_pkg::MAX_DIM_Y,
                                         idx / (mg3d_pkg::MAX_DIM_X * mg3d_pkg::MAX_DIM_Y),
                                         16'($urandom), 1'($urandom_range(0, 1)));
                                count++;
                            end
                        end
                    end
                    send_cmd(mg3d_pkg::ACT_COMPUTE, x, y, z, 16'($urandom),
                             1'($urandom_range(0, 1)));
                    count++;
                end
            end
            if ($urandom_range(0, 59) == 0)
                drain(0);
        end
    endtask

    initial begin
        sb = new;
        for (int r = 0; r < mg3d_pkg::REG_COUNT; r++) begin
            cfg_plan[10][r] = (r < mg3d_pkg::REG_KER_X) ? $urandom_range(1, 9)
                                                        : $urandom_range(0, 9);
            cfg_plan[11][r] = (r < mg3d_pkg::REG_KER_X) ? $urandom_range(1, 9)
                                                        : $urandom_range(1, 8);
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph / 4)
                0: begin
                    tx_idle_pct = 17;
                    rx_idle_pct = 61;
                end
                1: begin
                    tx_idle_pct = 61;
                    rx_idle_pct = 17;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (ph == 0) begin
                run_directed();
            end else begin
                drain(16);
                configure(ph);
                run_random(ITEMS_PER_PHASE);
            end
        end

        drain(0);
        repeat (600) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
